// File: rtl/core/length_prefixed_record_deframer_crc32_top_macros.svh
// assertion helpers used by the checker file
`ifndef LENGTH_PREFIXED_RECORD_DEFRAMER_CRC32_TOP_MACROS_SVH
`define LENGTH_PREFIXED_RECORD_DEFRAMER_CRC32_TOP_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define LPRD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define LPRD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lprd_pkg.sv
package lprd_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

  // parser phases
  localparam logic [2:0] PhCount = 3'd0;
  localparam logic [2:0] PhNlen  = 3'd1;
  localparam logic [2:0] PhName  = 3'd2;
  localparam logic [2:0] PhDlen  = 3'd3;
  localparam logic [2:0] PhData  = 3'd4;
  localparam logic [2:0] PhCrc   = 3'd5;
  localparam logic [2:0] PhDone  = 3'd6;

  typedef enum logic [1:0] {
    KindName   = 2'd0,
    KindData   = 2'd1,
    KindRecord = 2'd2,
    KindStatus = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusTruncated = 2'd1,
    StatusCrcError  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic        record_crc_ok;
    logic [1:0]  status;
    logic [31:0] good_count;
    logic        run_last;
  } out_item_t;

  // everything one input byte produces: one or two results
  typedef struct packed {
    out_item_t first;
    out_item_t second;
    logic      two;
  } event_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (CrcPoly & {32{r[0]}});
    end
    return r;
  endfunction

endpackage

// File: rtl/core/length_prefixed_record_deframer_crc32_top.sv
// Record deframer with CRC-32 check. Payload bytes enter through a push/full queue port, one
// per cycle whenever full is low; the parser and the per-byte CRC update finish within the
// accepting cycle, so a byte never waits on its predecessor. Every byte that yields results
// leaves one event in a QueueDepth-entry queue; the result side drains one result per pop,
// so a byte yielding two results (record, name or data result followed by payload status) takes
// two pops, and full rises only when the result side has fallen QueueDepth events behind. A
// result is registered in the queue before it shows on the result port, behind any older ones.
module length_prefixed_record_deframer_crc32_top #(
  parameter int unsigned QueueDepth = lprd_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  lprd_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output lprd_pkg::out_item_t result_o
);

  logic             accept;
  lprd_pkg::event_t ev;
  logic             ev_valid;
  lprd_pkg::event_t head;
  logic             head_empty;
  logic             head_pop;

  assign accept = push & ~full;

  lprd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .ev_o       (ev),
    .ev_valid_o (ev_valid)
  );

  lprd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept & ev_valid),
    .entry_i (ev),
    .full_o  (full),
    .pop_i   (head_pop),
    .entry_o (head),
    .empty_o (head_empty)
  );

  lprd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_empty_i (head_empty),
    .head_pop_o   (head_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .result_o     (result_o)
  );

endmodule

// File: rtl/core/lprd_front.sv
module lprd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  lprd_pkg::in_item_t item_i,
  output lprd_pkg::event_t  ev_o,
  output logic              ev_valid_o
);

  logic [2:0]  phase_q, phase_d;
  logic [1:0]  idx_q, idx_d;
  logic [23:0] acc_q, acc_d;
  logic [31:0] left_q, left_d;
  logic [31:0] recs_q, recs_d;
  logic [31:0] good_q, good_d;
  logic [31:0] crc_q, crc_d;

  logic                main_v, fin_v;
  lprd_pkg::out_item_t main_r, fin_r;
  logic [1:0]          fin_status;
  logic [31:0]         fld;
  logic                crc_ok;

  assign fld    = {item_i.in_byte, acc_q};
  assign crc_ok = (~crc_q) == fld;

  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    acc_d      = acc_q;
    left_d     = left_q;
    recs_d     = recs_q;
    good_d     = good_q;
    crc_d      = crc_q;
    main_v     = 1'b0;
    main_r     = '0;
    fin_v      = 1'b0;
    fin_status = lprd_pkg::StatusOk;

    unique case (phase_q) inside
      lprd_pkg::PhCount, lprd_pkg::PhNlen, lprd_pkg::PhDlen, lprd_pkg::PhCrc: begin
        if (idx_q == 2'd3) begin
          idx_d = '0;
          acc_d = '0;
          if (phase_q == lprd_pkg::PhCount) begin
            recs_d = fld;
            if (fld == '0) begin
              fin_v      = 1'b1;
              fin_status = lprd_pkg::StatusOk;
              phase_d    = lprd_pkg::PhDone;
            end else begin
              phase_d = lprd_pkg::PhNlen;
            end
          end else if (phase_q == lprd_pkg::PhNlen) begin
            left_d  = fld;
            phase_d = (fld == '0) ? lprd_pkg::PhDlen : lprd_pkg::PhName;
          end else if (phase_q == lprd_pkg::PhDlen) begin
            left_d  = fld;
            crc_d   = lprd_pkg::CrcInit;
            phase_d = (fld == '0) ? lprd_pkg::PhCrc : lprd_pkg::PhData;
          end else begin
            if (crc_ok) begin
              good_d = good_q + 32'd1;
              recs_d = recs_q - 32'd1;
            end
            main_v               = 1'b1;
            main_r.kind          = lprd_pkg::KindRecord;
            main_r.record_crc_ok = crc_ok;
            if (!crc_ok) begin
              fin_v      = 1'b1;
              fin_status = lprd_pkg::StatusCrcError;
              phase_d    = lprd_pkg::PhDone;
            end else if (recs_d == '0) begin
              fin_v      = 1'b1;
              fin_status = lprd_pkg::StatusOk;
              phase_d    = lprd_pkg::PhDone;
            end else begin
              phase_d = lprd_pkg::PhNlen;
            end
          end
        end else begin
          idx_d = idx_q + 2'd1;
          case (idx_q)
            2'd0:    acc_d[7:0]   = item_i.in_byte;
            2'd1:    acc_d[15:8]  = item_i.in_byte;
            default: acc_d[23:16] = item_i.in_byte;
          endcase
        end
      end
      lprd_pkg::PhName: begin
        main_v          = 1'b1;
        main_r.kind     = lprd_pkg::KindName;
        main_r.out_byte = item_i.in_byte;
        left_d          = left_q - 32'd1;
        if (left_d == '0) phase_d = lprd_pkg::PhDlen;
      end
      lprd_pkg::PhData: begin
        main_v          = 1'b1;
        main_r.kind     = lprd_pkg::KindData;
        main_r.out_byte = item_i.in_byte;
        crc_d           = lprd_pkg::crc_byte(crc_q, item_i.in_byte);
        left_d          = left_q - 32'd1;
        if (left_d == '0) phase_d = lprd_pkg::PhCrc;
      end
      default: ;
    endcase

    // payload ended before it was complete
    if (item_i.in_last && phase_d != lprd_pkg::PhDone) begin
      fin_v      = 1'b1;
      fin_status = lprd_pkg::StatusTruncated;
    end

    main_r.good_count = good_d;

    // payload boundary puts everything back to the start
    if (item_i.in_last) begin
      phase_d = lprd_pkg::PhCount;
      idx_d   = '0;
      acc_d   = '0;
      left_d  = '0;
      recs_d  = '0;
      good_d  = '0;
      crc_d   = lprd_pkg::CrcInit;
    end
  end

  always_comb begin
    fin_r            = '0;
    fin_r.kind       = lprd_pkg::KindStatus;
    fin_r.status     = fin_status;
    fin_r.good_count = main_r.good_count;
    fin_r.run_last   = 1'b1;
  end

  always_comb begin
    ev_o.two    = main_v & fin_v;
    ev_o.first  = main_v ? main_r : fin_r;
    ev_o.second = fin_r;
    if (main_v && !fin_v) ev_o.first.run_last = 1'b1;
    if (main_v && fin_v) ev_o.first.run_last = 1'b0;
  end

  assign ev_valid_o = main_v | fin_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lprd_pkg::PhCount;
      idx_q   <= '0;
      acc_q   <= '0;
      left_q  <= '0;
      recs_q  <= '0;
      good_q  <= '0;
      crc_q   <= lprd_pkg::CrcInit;
    end else if (accept_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      recs_q  <= recs_d;
      good_q  <= good_d;
      crc_q   <= crc_d;
    end
  end

endmodule

// File: rtl/core/lprd_queue.sv
module lprd_queue #(
  parameter int unsigned Depth = lprd_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lprd_pkg::event_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output lprd_pkg::event_t entry_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lprd_pkg::event_t  mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) count_d = count_q + CntW'(1);
    if (do_pop && !do_push) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

endmodule

// File: rtl/core/lprd_back.sv
module lprd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lprd_pkg::event_t    head_i,
  input  logic                head_empty_i,
  output logic                head_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output lprd_pkg::out_item_t result_o
);

  logic sel_q, sel_d;
  logic take;
  logic last_of_event;

  assign empty_o       = head_empty_i;
  assign result_o      = sel_q ? head_i.second : head_i.first;
  assign take          = pop_i & ~head_empty_i;
  // second result of a pair, or the only one
  assign last_of_event = sel_q | ~head_i.two;
  assign head_pop_o    = take & last_of_event;

  always_comb begin
    sel_d = sel_q;
    if (take) sel_d = ~last_of_event;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule

// File: rtl/core/lprd_checker.sv
`include "length_prefixed_record_deframer_crc32_top_macros.svh"

module lprd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input lprd_pkg::out_item_t result_i
);

  // a waiting result stays put until taken
  `LPRD_ASSERT_NXT(a_hold_valid, !empty && !pop, !empty, "result dropped while stalled")
  `LPRD_ASSERT_NXT(a_hold_data, !empty && !pop, $stable(result_i), "result changed while stalled")
  // status always closes the run of its byte
  `LPRD_ASSERT_IMP(a_status_last, !empty && result_i.kind == lprd_pkg::KindStatus,
                   result_i.run_last, "status result not marked last")
  // a failed record is always followed by the crc status
  `LPRD_ASSERT_IMP(a_bad_rec_more,
                   !empty && result_i.kind == lprd_pkg::KindRecord && !result_i.record_crc_ok,
                   !result_i.run_last, "failed record not followed by status")

endmodule

bind length_prefixed_record_deframer_crc32_top lprd_checker u_lprd_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_i (result_o)
);

// File: tb/length_prefixed_record_deframer_crc32_top_tb.sv
module length_prefixed_record_deframer_crc32_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RxHoldCycles = 120;
  localparam int unsigned DrainCycles  = 8;

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  lprd_pkg::in_item_t  in_item_i;
  logic                empty;
  logic                pop;
  lprd_pkg::out_item_t result_o;

  length_prefixed_record_deframer_crc32_top u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .in_item_i(in_item_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  bit          idle_on;
  bit          rx_hold_req;

  logic [7:0]          payload[$];
  lprd_pkg::out_item_t expected_results[$];
  lprd_pkg::out_item_t step_results[$];

  // parser shadow state
  logic [2:0]  parse_phase;
  logic [1:0]  word_idx;
  logic [31:0] word_acc;
  logic [31:0] bytes_remaining;
  logic [31:0] records_left;
  logic [31:0] good_total;
  logic [31:0] data_crc;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] acc;
    acc = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ lprd_pkg::CrcPoly;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

  function automatic void reset_parser();
    parse_phase     = lprd_pkg::PhCount;
    word_idx        = 2'd0;
    word_acc        = '0;
    bytes_remaining = '0;
    records_left    = '0;
    good_total      = '0;
    data_crc        = lprd_pkg::CrcInit;
  endfunction

  function automatic lprd_pkg::out_item_t make_result(input lprd_pkg::kind_e k,
                                                      input logic [7:0] b,
                                                      input logic ok,
                                                      input lprd_pkg::status_e st);
    lprd_pkg::out_item_t r;
    r.kind          = k;
    r.out_byte      = b;
    r.record_crc_ok = ok;
    r.status        = st;
    r.good_count    = good_total;
    r.run_last      = 1'b0;
    return r;
  endfunction

  function automatic void close_payload(input lprd_pkg::status_e st);
    step_results.push_back(make_result(lprd_pkg::KindStatus, 8'h00, 1'b0, st));
    parse_phase = lprd_pkg::PhDone;
  endfunction

  // works out the results one accepted byte causes and queues them
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [31:0] word;
    logic        ok;
    step_results.delete();
    case (parse_phase) inside
      lprd_pkg::PhCount, lprd_pkg::PhNlen, lprd_pkg::PhDlen, lprd_pkg::PhCrc: begin
        word = word_acc | ({24'd0, b} << (8 * word_idx));
        if (word_idx != 2'd3) begin
          word_acc = word;
          word_idx = word_idx + 2'd1;
        end else begin
          word_idx = 2'd0;
          word_acc = '0;
          case (parse_phase)
            lprd_pkg::PhCount: begin
              records_left = word;
              if (word == 32'd0) begin
                close_payload(lprd_pkg::StatusOk);
              end else begin
                parse_phase = lprd_pkg::PhNlen;
              end
            end
            lprd_pkg::PhNlen: begin
              bytes_remaining = word;
              parse_phase = (word == 32'd0) ? lprd_pkg::PhDlen : lprd_pkg::PhName;
            end
            lprd_pkg::PhDlen: begin
              bytes_remaining = word;
              data_crc = lprd_pkg::CrcInit;
              parse_phase = (word == 32'd0) ? lprd_pkg::PhCrc : lprd_pkg::PhData;
            end
            default: begin
              ok = ((~data_crc) == word);
              if (ok) begin
                good_total++;
                records_left--;
              end
              step_results.push_back(make_result(lprd_pkg::KindRecord, 8'h00, ok,
                                                 lprd_pkg::StatusOk));
              if (!ok) begin
                close_payload(lprd_pkg::StatusCrcError);
              end else if (records_left == 32'd0) begin
                close_payload(lprd_pkg::StatusOk);
              end else begin
                parse_phase = lprd_pkg::PhNlen;
              end
            end
          endcase
        end
      end
      lprd_pkg::PhName: begin
        step_results.push_back(make_result(lprd_pkg::KindName, b, 1'b0, lprd_pkg::StatusOk));
        bytes_remaining--;
        if (bytes_remaining == 32'd0) parse_phase = lprd_pkg::PhDlen;
      end
      lprd_pkg::PhData: begin
        step_results.push_back(make_result(lprd_pkg::KindData, b, 1'b0, lprd_pkg::StatusOk));
        data_crc = crc32_update(data_crc, b);
        bytes_remaining--;
        if (bytes_remaining == 32'd0) parse_phase = lprd_pkg::PhCrc;
      end
      default: ;
    endcase
    if (last && parse_phase != lprd_pkg::PhDone) close_payload(lprd_pkg::StatusTruncated);
    if (step_results.size() > 0) step_results[step_results.size() - 1].run_last = 1'b1;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
    if (last) reset_parser();
  endtask

  always @(posedge clk_i) begin : check_results
    lprd_pkg::out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result %0h", result_o));
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 32'(result_o.kind), 32'(want.kind));
        check_field("out_byte", 32'(result_o.out_byte), 32'(want.out_byte));
        check_field("record_crc_ok", 32'(result_o.record_crc_ok), 32'(want.record_crc_ok));
        check_field("status", 32'(result_o.status), 32'(want.status));
        check_field("good_count", result_o.good_count, want.good_count);
        check_field("run_last", 32'(result_o.run_last), 32'(want.run_last));
      end
    end
  end

  // result side: random pop bursts, plus one long hold on request
  initial begin : result_drain
    int unsigned held;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        pop = 1'b0;
        for (held = 1; held < RxHoldCycles; held++) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        pop = 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk_i);
      end else begin
        pop = 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk_i);
      push = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push = 1'b1;
    in_item_i.in_byte = b;
    in_item_i.in_last = last;
    do @(posedge clk_i); while (full);
    parse_byte(b, last);
  endtask

  task automatic send_payload();
    foreach (payload[i]) send_byte(payload[i], i == payload.size() - 1);
  endtask

  function automatic void put_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) payload.push_back(w[8*k +: 8]);
  endfunction

  function automatic logic [31:0] pick_len(input int unsigned min_len);
    if ($urandom_range(0, 7) == 0) return min_len + $urandom_range(9, 40);
    return min_len + $urandom_range(0, 8);
  endfunction

  // well-formed records with random content; bad_rec gets a corrupted crc
  task automatic build_records(input int n_rec, input int bad_rec,
                               input logic [31:0] count_field, input int unsigned min_len);
    logic [31:0] nlen;
    logic [31:0] dlen;
    logic [31:0] stored_crc;
    logic [7:0]  b;
    payload.delete();
    put_word(count_field);
    for (int r = 0; r < n_rec; r++) begin
      nlen = pick_len(min_len);
      put_word(nlen);
      repeat (nlen) payload.push_back(8'($urandom));
      dlen = pick_len(min_len);
      put_word(dlen);
      stored_crc = lprd_pkg::CrcInit;
      repeat (dlen) begin
        b = 8'($urandom);
        stored_crc = crc32_update(stored_crc, b);
        payload.push_back(b);
      end
      stored_crc = ~stored_crc;
      if (r == bad_rec) begin
        if ($urandom_range(0, 1) == 0) begin
          stored_crc ^= 32'd1 << $urandom_range(0, 31);
        end else begin
          stored_crc ^= $urandom_range(1, 32'hFFFF_FFFF);
        end
      end
      put_word(stored_crc);
    end
  endtask

  task automatic test_directed();
    // no records: ok at once
    payload.delete();
    put_word(32'd0);
    send_payload();
    // one record with empty name and empty data, crc of the empty string
    payload.delete();
    put_word(32'd1);
    put_word(32'd0);
    put_word(32'd0);
    put_word(32'd0);
    send_payload();
    // payload of a single byte
    payload.delete();
    payload.push_back(8'hFF);
    send_payload();
    // all-ones record count, cut off right after the name
    payload.delete();
    put_word(32'hFFFF_FFFF);
    put_word(32'd1);
    payload.push_back(8'h00);
    send_payload();
  endtask

  task automatic test_random_payloads(input int unsigned byte_budget);
    int unsigned sent;
    int unsigned mode;
    int unsigned cut;
    int          n_rec;
    int          bad;
    sent = 0;
    while (sent < byte_budget) begin
      mode = $urandom_range(0, 9);
      n_rec = $urandom_range(1, 4);
      if ($urandom_range(0, 9) == 0) n_rec = 0;
      if ($urandom_range(0, 4) == 0) begin
        bad = $urandom_range(0, n_rec);
      end else begin
        bad = -1;
      end
      if (mode == 8) begin
        // record count that does not match the records present
        build_records(n_rec, bad, $urandom, 0);
      end else begin
        build_records(n_rec, bad, n_rec, 0);
      end
      if (mode == 6 && payload.size() > 1) begin
        cut = $urandom_range(1, payload.size() - 1);
        while (payload.size() > cut) void'(payload.pop_back());
      end else if (mode == 7) begin
        repeat ($urandom_range(1, 6)) payload.push_back(8'($urandom));
      end else if (mode == 9) begin
        payload.delete();
        repeat ($urandom_range(1, 24)) payload.push_back(8'($urandom));
      end
      send_payload();
      sent += payload.size();
    end
  endtask

  // long result-side stall while bytes keep coming, so the block fills up
  task automatic test_backpressure();
    rx_hold_req = 1'b1;
    build_records(2, -1, 2, 16);
    send_payload();
  endtask

  task automatic test_streaming();
    idle_on = 1'b0;
    test_random_payloads(200);
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    in_item_i = '0;
    idle_on = 1'b1;
    rx_hold_req = 1'b0;
    reset_parser();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_payloads(1250);
    test_backpressure();
    test_streaming();

    @(negedge clk_i);
    push = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
